/* rtl/pds_pkg.sv */
// shared types and constants of the per-type defect statistics block
// no dependencies
package pds_pkg;

    localparam int TYPE_COUNT = 16;
    localparam int TYPE_W     = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

    localparam int OP_W    = 2;
    localparam int DTYPE_W = 4;
    localparam int SIZE_W  = 16;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 16;
    localparam int PCT_W   = 15;
    localparam int TOTAL_W = 32;

    localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

    // size * 100, kept 7 bits wider than the size
    localparam int PROD_W  = SIZE_W + 7;
    localparam int STEP_W  = $clog2(PCT_W + 1);

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DTYPE_W-1:0] dtype;
        logic [SIZE_W-1:0]  size;
        logic [PCT_W-1:0]   inc;
        logic               add_ok;
    } cmd_t;

    typedef struct packed {
        logic               accepted;
        logic               entry_valid;
        logic [CNT_W-1:0]   count;
        logic [PCT_W-1:0]   percent;
        logic [SIZE_W-1:0]  smallest;
        logic [SIZE_W-1:0]  largest;
        logic [TOTAL_W-1:0] total;
    } rslt_t;

endpackage

/* rtl/pds_divider.sv */
// bit-serial restoring divider for the percent increment: size*25600/length
// valid only for size below length; one quotient bit per cycle; uses pds_pkg
module pds_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pds_pkg::SIZE_W-1:0]  size,
    input  logic [pds_pkg::LEN_W-1:0]   len,
    output logic                        done,
    output logic [pds_pkg::PCT_W-1:0]   quotient
);

    logic [pds_pkg::PROD_W-1:0]  prod;
    logic [pds_pkg::LEN_W-1:0]   rem_reg;
    logic [pds_pkg::LEN_W-1:0]   div_reg;
    logic [pds_pkg::PCT_W-1:0]   shift_reg;
    logic [pds_pkg::STEP_W-1:0]  step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [pds_pkg::LEN_W:0]     trial;
    logic                        qbit;

    // size * 100 = size*64 + size*32 + size*4
    assign prod = (pds_pkg::PROD_W'(size) << 6) + (pds_pkg::PROD_W'(size) << 5)
                + (pds_pkg::PROD_W'(size) << 2);

    assign trial = {rem_reg, shift_reg[pds_pkg::PCT_W-1]} - {1'b0, div_reg};
    assign qbit  = ~trial[pds_pkg::LEN_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == pds_pkg::STEP_W'(pds_pkg::PCT_W - 1)) begin
                    busy_reg <= 1'b0;
                end
                done_reg <= (step_reg == pds_pkg::STEP_W'(pds_pkg::PCT_W - 1));
                step_reg <= step_reg + pds_pkg::STEP_W'(1);
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // upper dividend bits preload the remainder, the rest shift in
            rem_reg   <= prod[pds_pkg::PROD_W-1:7];
            shift_reg <= {prod[6:0], 8'd0};
            div_reg   <= len;
        end else if (busy_reg) begin
            if (qbit) begin
                rem_reg <= trial[pds_pkg::LEN_W-1:0];
            end else begin
                rem_reg <= {rem_reg[pds_pkg::LEN_W-2:0], shift_reg[pds_pkg::PCT_W-1]};
            end
            shift_reg <= {shift_reg[pds_pkg::PCT_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

/* rtl/pds_table.sv */
// per-type statistics table: valid bits, entry stores and the update logic
// uses pds_pkg command and result structs
module pds_table (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            upd_en,
    input  pds_pkg::cmd_t   cmd,
    output pds_pkg::rslt_t  rslt
);

    logic [pds_pkg::TYPE_COUNT-1:0] valid_reg;
    logic [pds_pkg::CNT_W-1:0]      count_reg    [pds_pkg::TYPE_COUNT];
    logic [pds_pkg::PCT_W-1:0]      percent_reg  [pds_pkg::TYPE_COUNT];
    logic [pds_pkg::SIZE_W-1:0]     smallest_reg [pds_pkg::TYPE_COUNT];
    logic [pds_pkg::SIZE_W-1:0]     largest_reg  [pds_pkg::TYPE_COUNT];
    logic [pds_pkg::TOTAL_W-1:0]    total_reg    [pds_pkg::TYPE_COUNT];

    logic [pds_pkg::TYPE_W-1:0]     idx;
    logic                           in_range;
    logic                           old_vld;
    logic                           post_vld;
    logic                           report;
    logic [pds_pkg::PCT_W:0]        pct_sum;
    logic [pds_pkg::TOTAL_W:0]      total_sum;
    logic [pds_pkg::CNT_W-1:0]      count_next;
    logic [pds_pkg::PCT_W-1:0]      percent_next;
    logic [pds_pkg::SIZE_W-1:0]     smallest_next;
    logic [pds_pkg::SIZE_W-1:0]     largest_next;
    logic [pds_pkg::TOTAL_W-1:0]    total_next;

    assign idx      = pds_pkg::TYPE_W'(cmd.dtype);
    assign in_range = (int'(cmd.dtype) < pds_pkg::TYPE_COUNT);
    assign old_vld  = in_range && valid_reg[idx];
    assign post_vld = old_vld || cmd.add_ok;
    assign report   = post_vld && (cmd.op == pds_pkg::OP_ADD || cmd.op == pds_pkg::OP_READ);

    assign pct_sum   = {1'b0, percent_reg[idx]} + {1'b0, cmd.inc};
    assign total_sum = {1'b0, total_reg[idx]} + (pds_pkg::TOTAL_W + 1)'(cmd.size);

    always_comb begin
        if (!cmd.add_ok) begin
            count_next    = count_reg[idx];
            percent_next  = percent_reg[idx];
            smallest_next = smallest_reg[idx];
            largest_next  = largest_reg[idx];
            total_next    = total_reg[idx];
        end else if (!old_vld) begin
            count_next    = pds_pkg::CNT_W'(1);
            percent_next  = cmd.inc;
            smallest_next = cmd.size;
            largest_next  = cmd.size;
            total_next    = pds_pkg::TOTAL_W'(cmd.size);
        end else begin
            count_next    = (&count_reg[idx]) ? count_reg[idx]
                                              : count_reg[idx] + pds_pkg::CNT_W'(1);
            percent_next  = (pct_sum > {1'b0, pds_pkg::PCT_FULL}) ? pds_pkg::PCT_FULL
                                                                 : pct_sum[pds_pkg::PCT_W-1:0];
            smallest_next = (cmd.size < smallest_reg[idx]) ? cmd.size : smallest_reg[idx];
            largest_next  = (cmd.size > largest_reg[idx]) ? cmd.size : largest_reg[idx];
            total_next    = total_sum[pds_pkg::TOTAL_W] ? '1 : total_sum[pds_pkg::TOTAL_W-1:0];
        end
    end

    always_comb begin
        rslt          = '0;
        rslt.accepted = cmd.add_ok;
        if (report) begin
            rslt.entry_valid = 1'b1;
            rslt.count       = count_next;
            rslt.percent     = percent_next;
            rslt.smallest    = smallest_next;
            rslt.largest     = largest_next;
            rslt.total       = total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (upd_en) begin
            if (cmd.op == pds_pkg::OP_CLEAR) begin
                valid_reg <= '0;
            end else if (cmd.add_ok) begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_en && cmd.add_ok) begin
            count_reg[idx]    <= count_next;
            percent_reg[idx]  <= percent_next;
            smallest_reg[idx] <= smallest_next;
            largest_reg[idx]  <= largest_next;
            total_reg[idx]    <= total_next;
        end
    end

endmodule

/* rtl/per_type_defect_statistics.sv */
// Per-type defect statistics, top level.
// Input channel s_*: op (0 add, 1 read, 2 clear), type index, size.
// Result channel m_*: one result transaction per input transaction, in order:
//   accepted, entry_valid and the addressed entry after the op (count,
//   percent in Q8 capped at 100.0, smallest, largest, total).
// Config channel cfg_*: writes overall_length; always ready, write only
//   while no transaction is in flight. A zero length rejects every add.
// Ops: an add with size below the length runs the bit-serial divider,
//   one quotient bit per cycle for 15 bits, before the table update and
//   the result register; other items go straight to the update.
// One item is in work at a time; s_ready is high again once the result is
//   in the output register, so the next item is taken while it waits.
// A stalled receiver holds the finished result in the output register and
//   the next result waits inside until the register frees.
// Reset (aresetn low, synchronous) clears all entries, the length and the
//   result valid flag.
// uses pds_pkg, pds_divider, pds_table
module per_type_defect_statistics (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pds_pkg::LEN_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pds_pkg::OP_W-1:0]      s_op,
    input  logic [pds_pkg::DTYPE_W-1:0]   s_dtype,
    input  logic [pds_pkg::SIZE_W-1:0]    s_dsize,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_accepted,
    output logic                          m_entry_valid,
    output logic [pds_pkg::CNT_W-1:0]     m_count,
    output logic [pds_pkg::PCT_W-1:0]     m_percent,
    output logic [pds_pkg::SIZE_W-1:0]    m_min_size,
    output logic [pds_pkg::SIZE_W-1:0]    m_max_size,
    output logic [pds_pkg::TOTAL_W-1:0]   m_total_size
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD
    } state_t;

    state_t                         state_reg;
    logic [pds_pkg::LEN_W-1:0]      len_reg;
    pds_pkg::cmd_t                  cmd_reg;
    pds_pkg::rslt_t                 rslt_reg;
    pds_pkg::rslt_t                 tbl_rslt;
    logic                           m_valid_reg;
    logic                           s_fire;
    logic                           add_ok;
    logic                           div_start;
    logic                           div_done;
    logic [pds_pkg::PCT_W-1:0]      div_q;
    logic                           out_free;
    logic                           upd_en;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign upd_en    = (state_reg == ST_UPD) && out_free;

    assign add_ok = (s_op == pds_pkg::OP_ADD) && (int'(s_dtype) < pds_pkg::TYPE_COUNT)
                 && (s_dsize != '0) && (len_reg != '0);
    assign div_start = s_fire && add_ok && (s_dsize < len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_valid) begin
            len_reg <= cfg_data;
        end
    end

    pds_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .size     (s_dsize),
        .len      (len_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    pds_table u_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd_en  (upd_en),
        .cmd     (cmd_reg),
        .rslt    (tbl_rslt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !upd_en) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        cmd_reg.op     <= s_op;
                        cmd_reg.dtype  <= s_dtype;
                        cmd_reg.size   <= s_dsize;
                        cmd_reg.add_ok <= add_ok;
                        cmd_reg.inc    <= pds_pkg::PCT_FULL;
                        state_reg      <= div_start ? ST_DIV : ST_UPD;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        cmd_reg.inc <= div_q;
                        state_reg   <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (out_free) begin
                        rslt_reg    <= tbl_rslt;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = rslt_reg.accepted;
    assign m_entry_valid = rslt_reg.entry_valid;
    assign m_count       = rslt_reg.count;
    assign m_percent     = rslt_reg.percent;
    assign m_min_size    = rslt_reg.smallest;
    assign m_max_size    = rslt_reg.largest;
    assign m_total_size  = rslt_reg.total;

endmodule

/* rtl/pds_checker.sv */
// port-level checks of the per-type defect statistics block
// uses pds_pkg; bound to per_type_defect_statistics
module pds_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_accepted,
    input  logic                          m_entry_valid,
    input  logic [pds_pkg::CNT_W-1:0]     m_count,
    input  logic [pds_pkg::PCT_W-1:0]     m_percent,
    input  logic [pds_pkg::SIZE_W-1:0]    m_min_size,
    input  logic [pds_pkg::SIZE_W-1:0]    m_max_size,
    input  logic [pds_pkg::TOTAL_W-1:0]   m_total_size
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count) && $stable(m_total_size))
        else $error("stalled result changed");

    // an accepted add leaves a valid entry
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_entry_valid)
        else $error("accepted add without valid entry");

    // percent stays capped
    a_pct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_percent <= pds_pkg::PCT_FULL)
        else $error("percent above cap");

    // invalid entry reports zeros
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_entry_valid |-> m_count == '0 && m_percent == '0
            && m_min_size == '0 && m_max_size == '0 && m_total_size == '0)
        else $error("invalid entry with nonzero fields");

    // valid entry is consistent
    a_ent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_entry_valid |-> m_count != '0 && m_min_size != '0
            && m_min_size <= m_max_size)
        else $error("inconsistent entry");

endmodule

bind per_type_defect_statistics pds_checker u_pds_checker (.*);
